// ----- sv/u8u2_pkg.sv -----
package u8u2_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned PendW  = 2;

  localparam logic [UnitW-1:0] CountMax = 16'hffff;

  // Continuation bytes still expected after the current byte
  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] PendOne  = 2'd1;
  localparam logic [PendW-1:0] PendTwo  = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic [UnitW-1:0] unit_count;
    logic             last_unit;
    logic             truncated;
  } result_t;

  function automatic logic [UnitW-1:0] swap_bytes(input logic [UnitW-1:0] u);
    swap_bytes = {u[ByteW-1:0], u[UnitW-1:ByteW]};
  endfunction

endpackage

// ----- sv/u8u2_in_stage.sv -----
module u8u2_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  u8u2_pkg::in_item_t in_item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output u8u2_pkg::in_item_t item_o
);
  import u8u2_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ----- sv/u8u2_decode.sv -----
module u8u2_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  u8u2_pkg::in_item_t item_i,
  input  logic               big_endian_i,
  output logic               done_o,
  output u8u2_pkg::result_t  result_o
);
  import u8u2_pkg::*;

  logic [PendW-1:0] pend_q, pend_d;
  logic [UnitW-1:0] part_q, part_d;
  logic [UnitW-1:0] count_q, count_d;
  logic [UnitW-1:0] unit;
  logic [UnitW-1:0] count_next;
  logic             done, trunc;
  logic [ByteW-1:0] b;

  assign b = item_i.in_byte;

  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    unit   = '0;
    done   = 1'b0;
    trunc  = 1'b0;
    unique case (pend_q)
      PendNone: begin
        if (!b[7]) begin
          unit = {9'd0, b[6:0]};
          done = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          part_d = {5'd0, b[4:0], 6'd0};
          pend_d = PendOne;
        end else begin
          part_d = {b[3:0], 12'd0};
          pend_d = PendTwo;
        end
      end
      PendTwo: begin
        part_d = part_q | {4'd0, b[5:0], 6'd0};
        pend_d = PendOne;
      end
      default: begin
        // finish the sequence; a pending of three acts as one
        unit   = part_q | {10'd0, b[5:0]};
        part_d = '0;
        pend_d = PendNone;
        done   = 1'b1;
      end
    endcase

    if (!done && item_i.end_of_string) begin
      unit  = part_d;
      trunc = 1'b1;
      done  = 1'b1;
    end

    count_next = (count_q == CountMax) ? count_q : count_q + UnitW'(1);
    count_d    = done ? count_next : count_q;

    if (item_i.end_of_string) begin
      pend_d  = PendNone;
      part_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= PendNone;
      part_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      pend_q  <= pend_d;
      part_q  <= part_d;
      count_q <= count_d;
    end
  end

  assign done_o              = done;
  assign result_o.code_unit  = big_endian_i ? unit : swap_bytes(unit);
  assign result_o.unit_count = count_next;
  assign result_o.last_unit  = item_i.end_of_string;
  assign result_o.truncated  = trunc;
endmodule

// ----- sv/u8u2_out_stage.sv -----
module u8u2_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  u8u2_pkg::result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output u8u2_pkg::result_t result_o
);
  import u8u2_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;
endmodule

// ----- sv/utf8_to_ucs2_stream_decoder.sv -----
// Two-stage decoder: input register, then decode into the result register.
// An accepted byte waits in the input register until the result register is free.
// Throughput: one byte per cycle; a result waiting on a stall holds the input stage.
// Reset (rst_ni low, asynchronous): no pending sequence, count zero, big_endian 1,
// both stages empty.
module utf8_to_ucs2_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic [15:0] unit_count_o,
  output logic        last_unit_o,
  output logic        truncated_o
);
  import u8u2_pkg::*;

  logic     big_endian_q;
  in_item_t in_item, s1_item;
  logic     s1_valid, advance, free, done;
  result_t  dec_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      big_endian_q <= cfg_data_i;
    end
  end

  assign in_item.in_byte       = in_byte_i;
  assign in_item.end_of_string = end_of_string_i;

  // advance whenever the result slot can take whatever this byte produces
  assign advance = s1_valid && free;

  u8u2_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  u8u2_decode u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .item_i       (s1_item),
    .big_endian_i (big_endian_q),
    .done_o       (done),
    .result_o     (dec_res)
  );

  u8u2_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && done),
    .result_i    (dec_res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign code_unit_o  = out_res.code_unit;
  assign unit_count_o = out_res.unit_count;
  assign last_unit_o  = out_res.last_unit;
  assign truncated_o  = out_res.truncated;

  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> last_unit_o)
    else $error("truncated unit not marked last");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unit_count_o != 16'd0)
    else $error("result with zero unit count");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input stage lost a request while blocked");

  a_eos_always_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_item.end_of_string |=> out_valid_o && last_unit_o)
    else $error("end of string produced no final unit");
endmodule
